// ===== hdl/jvr_pkg.sv =====
// Package for the jog velocity ramp integrator: widths, types and datapath operation codes.
package jvr_pkg;

  localparam int AXES    = 4;
  localparam int AXIS_W  = 2;
  localparam int CFG_W   = 31;
  localparam int DT_W    = 16;
  localparam int VAL_W   = 32;
  localparam int PROD_W  = CFG_W + DT_W;
  localparam int MUL_A_W = VAL_W + 3;
  localparam int MUL_B_W = DT_W + 1;
  localparam int MOV_W   = 64;
  localparam int SUM_W   = 48;
  localparam int DIV_CNT_W = 5;

  localparam logic [1:0] REG_HALF_SPAN  = 2'd0;
  localparam logic [1:0] REG_MAX_SPEED  = 2'd1;
  localparam logic [1:0] REG_ACCEL_RATE = 2'd2;
  localparam logic [1:0] REG_DECEL_RATE = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] half_span;
    logic [CFG_W-1:0] max_speed;
    logic [CFG_W-1:0] accel_rate;
    logic [CFG_W-1:0] decel_rate;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_DEC,
    OP_MUL_ACC,
    OP_PARTIAL,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_FULL,
    OP_SNAP,
    OP_COAST,
    OP_MAC,
    OP_SUM,
    OP_WRITE
  } dp_op_t;

  typedef struct packed {
    logic axis_ok;
    logic decel_need;
    logic accel_need;
    logic over;
    logic partial;
    logic div_done;
    logic phase_dec;
    logic out_free;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_DEC,
    ST_TEST,
    ST_DIV,
    ST_MAC_PH,
    ST_CHK_ACC,
    ST_COAST,
    ST_MAC_CO,
    ST_SUM,
    ST_WRITE
  } state_t;

endpackage

// ===== hdl/jvr_regs.sv =====
// APB-style configuration register file.
module jvr_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output jvr_pkg::cfg_t      cfg
);
  import jvr_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_span  <= '0;
      cfg_r.max_speed  <= CFG_W'(65536);
      cfg_r.accel_rate <= CFG_W'(65536);
      cfg_r.decel_rate <= CFG_W'(65536);
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_HALF_SPAN:  cfg_r.half_span  <= cfg_pwdata[CFG_W-1:0];
        REG_MAX_SPEED:  cfg_r.max_speed  <= cfg_pwdata[CFG_W-1:0];
        REG_ACCEL_RATE: cfg_r.accel_rate <= cfg_pwdata[CFG_W-1:0];
        REG_DECEL_RATE: cfg_r.decel_rate <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_HALF_SPAN:  cfg_prdata = {1'b0, cfg_r.half_span};
      REG_MAX_SPEED:  cfg_prdata = {1'b0, cfg_r.max_speed};
      REG_ACCEL_RATE: cfg_prdata = {1'b0, cfg_r.accel_rate};
      REG_DECEL_RATE: cfg_prdata = {1'b0, cfg_r.decel_rate};
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

// ===== hdl/jvr_ctrl.sv =====
// Controller state machine that sequences the ramp phases through the datapath.
module jvr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  jvr_pkg::dp_status_t  status,
  output jvr_pkg::dp_op_t      op
);
  import jvr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = ST_CHK_DEC;
        end
      end
      ST_CHK_DEC: begin
        if (!status.axis_ok) begin
          state_nxt = ST_WRITE;
        end else if (status.decel_need) begin
          op        = OP_MUL_DEC;
          state_nxt = ST_TEST;
        end else begin
          state_nxt = ST_CHK_ACC;
        end
      end
      ST_TEST: begin
        if (status.partial) begin
          op        = OP_PARTIAL;
          state_nxt = ST_MAC_PH;
        end else begin
          op        = OP_DIV_START;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          op        = OP_FULL;
          state_nxt = ST_MAC_PH;
        end else begin
          op = OP_DIV_STEP;
        end
      end
      ST_MAC_PH: begin
        op        = OP_MAC;
        state_nxt = status.phase_dec ? ST_CHK_ACC : ST_COAST;
      end
      ST_CHK_ACC: begin
        if (status.accel_need) begin
          if (status.over) begin
            op        = OP_SNAP;
            state_nxt = ST_COAST;
          end else begin
            op        = OP_MUL_ACC;
            state_nxt = ST_TEST;
          end
        end else begin
          state_nxt = ST_COAST;
        end
      end
      ST_COAST: begin
        op        = OP_COAST;
        state_nxt = ST_MAC_CO;
      end
      ST_MAC_CO: begin
        op        = OP_MAC;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        op        = OP_SUM;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (status.out_free) begin
          op        = OP_WRITE;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/jvr_dp.sv =====
// Datapath: axis state, shared multiplier, restoring divider, accumulator and output register.
module jvr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  jvr_pkg::dp_op_t               op,
  output jvr_pkg::dp_status_t           status,
  input  jvr_pkg::cfg_t                 cfg,
  input  logic [jvr_pkg::AXIS_W-1:0]    in_axis,
  input  logic                          in_key_negative,
  input  logic                          in_key_positive,
  input  logic [jvr_pkg::DT_W-1:0]      in_delta_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [jvr_pkg::VAL_W-1:0] out_new_position,
  output logic signed [jvr_pkg::VAL_W-1:0] out_new_speed
);
  import jvr_pkg::*;

  logic signed [VAL_W-1:0]   speed_r [AXES];
  logic signed [VAL_W-1:0]   posn_r  [AXES];

  logic [AXIS_W-1:0]         axis_r;
  logic                      neg_r, pos_key_r;
  logic signed [VAL_W-1:0]   v_r;
  logic signed [VAL_W-1:0]   p_r;
  logic [DT_W-1:0]           rem_r;
  logic signed [MOV_W-1:0]   mov_r;
  logic [PROD_W-1:0]         prod_r;
  logic [VAL_W-1:0]          gap_r;
  logic                      phase_dec_r;
  logic signed [MUL_A_W-1:0] mul_a_r;
  logic signed [MUL_B_W-1:0] mul_b_r;
  logic [VAL_W:0]            div_rem_r;
  logic [DT_W-1:0]           q_r;
  logic [DIV_CNT_W-1:0]      cnt_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic                      out_valid_r;
  logic signed [VAL_W-1:0]   out_pos_r, out_spd_r;

  logic                      cmd_pos, cmd_neg, cmd_zero;
  logic                      v_neg, v_zero;
  logic signed [VAL_W:0]     along, target, v_ext;
  logic [VAL_W-1:0]          mag;
  logic                      axis_ok;
  logic [CFG_W-1:0]          rate;
  logic signed [VAL_W:0]     dv_s;
  logic [VAL_W:0]            div_sh;
  logic signed [MUL_A_W+MUL_B_W-1:0] mprod;
  logic signed [MOV_W-1:0]   mov_rnd;
  logic signed [SUM_W-1:0]   hs_s;

  // Both keys held means no command.
  assign cmd_pos  = pos_key_r & ~neg_r;
  assign cmd_neg  = neg_r & ~pos_key_r;
  assign cmd_zero = ~(cmd_pos | cmd_neg);
  assign v_neg    = v_r[VAL_W-1];
  assign v_zero   = (v_r == '0);
  assign v_ext    = (VAL_W+1)'(v_r);
  assign along    = cmd_pos ? v_ext : (cmd_neg ? -v_ext : '0);
  assign target   = cmd_pos ? $signed({2'b00, cfg.max_speed})
                  : (cmd_neg ? -$signed({2'b00, cfg.max_speed}) : '0);
  assign mag      = v_neg ? VAL_W'(-v_ext) : VAL_W'(v_r);
  assign axis_ok  = ({1'b0, axis_r} < (AXIS_W+1)'(AXES));
  assign rate     = phase_dec_r ? cfg.decel_rate : cfg.accel_rate;
  assign div_sh   = {div_rem_r[VAL_W-1:0], 1'b0};
  assign mprod    = mul_a_r * mul_b_r;
  assign mov_rnd  = mov_r + MOV_W'(65536);
  assign hs_s     = SUM_W'({1'b0, cfg.half_span});

  // Signed speed change of a partial phase: toward zero when braking, along the command else.
  always_comb begin
    dv_s = $signed({2'b00, prod_r[PROD_W-1:DT_W]});
    if (phase_dec_r ? !v_neg : cmd_neg) begin
      dv_s = -dv_s;
    end
  end

  assign status.axis_ok    = axis_ok;
  assign status.decel_need = (rem_r != '0) && !v_zero && (cmd_zero || (cmd_pos == v_neg));
  assign status.accel_need = (rem_r != '0) && !cmd_zero && (v_zero || (cmd_neg == v_neg));
  assign status.over       = along >= $signed({2'b00, cfg.max_speed});
  assign status.partial    = {gap_r, {DT_W{1'b0}}} > (VAL_W+DT_W)'(prod_r);
  assign status.div_done   = (cnt_r == '0);
  assign status.phase_dec  = phase_dec_r;
  assign status.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        axis_r    <= in_axis;
        neg_r     <= in_key_negative;
        pos_key_r <= in_key_positive;
        v_r       <= speed_r[in_axis];
        p_r       <= posn_r[in_axis];
        rem_r     <= in_delta_time;
        mov_r     <= '0;
      end
      OP_MUL_DEC: begin
        phase_dec_r <= 1'b1;
        prod_r      <= rem_r * cfg.decel_rate;
        gap_r       <= mag;
      end
      OP_MUL_ACC: begin
        phase_dec_r <= 1'b0;
        prod_r      <= rem_r * cfg.accel_rate;
        gap_r       <= VAL_W'($signed({2'b00, cfg.max_speed}) - along);
      end
      OP_PARTIAL: begin
        mul_a_r <= MUL_A_W'(v_ext) + MUL_A_W'(v_ext) + MUL_A_W'(dv_s);
        mul_b_r <= $signed({1'b0, rem_r});
        v_r     <= VAL_W'(v_ext + dv_s);
        rem_r   <= '0;
      end
      OP_DIV_START: begin
        div_rem_r <= {1'b0, gap_r};
        q_r       <= '0;
        cnt_r     <= DIV_CNT_W'(DT_W);
      end
      OP_DIV_STEP: begin
        if (div_sh >= {2'b00, rate}) begin
          div_rem_r <= div_sh - {2'b00, rate};
          q_r       <= {q_r[DT_W-2:0], 1'b1};
        end else begin
          div_rem_r <= div_sh;
          q_r       <= {q_r[DT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      OP_FULL: begin
        mul_a_r <= phase_dec_r ? MUL_A_W'(v_ext) : MUL_A_W'(v_ext) + MUL_A_W'(target);
        mul_b_r <= $signed({1'b0, q_r});
        v_r     <= phase_dec_r ? '0 : VAL_W'(target);
        rem_r   <= rem_r - q_r;
      end
      OP_SNAP: begin
        v_r <= VAL_W'(target);
      end
      OP_COAST: begin
        mul_a_r <= MUL_A_W'(v_ext) + MUL_A_W'(v_ext);
        mul_b_r <= $signed({1'b0, rem_r});
      end
      OP_MAC: begin
        mov_r <= mov_r + MOV_W'(mprod);
      end
      OP_SUM: begin
        sum_r <= SUM_W'(p_r) + SUM_W'(mov_rnd >>> 17);
      end
      default: ;
    endcase
  end

  // Result register and per-axis state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        speed_r[i] <= '0;
        posn_r[i]  <= '0;
      end
    end else begin
      if (op == OP_WRITE) begin
        out_valid_r <= 1'b1;
        if (!axis_ok) begin
          out_pos_r <= '0;
          out_spd_r <= '0;
        end else if (sum_r > hs_s) begin
          out_pos_r       <= VAL_W'(hs_s);
          out_spd_r       <= '0;
          posn_r[axis_r]  <= VAL_W'(hs_s);
          speed_r[axis_r] <= '0;
        end else if (sum_r < -hs_s) begin
          out_pos_r       <= VAL_W'(-hs_s);
          out_spd_r       <= '0;
          posn_r[axis_r]  <= VAL_W'(-hs_s);
          speed_r[axis_r] <= '0;
        end else begin
          out_pos_r       <= VAL_W'(sum_r);
          out_spd_r       <= v_r;
          posn_r[axis_r]  <= VAL_W'(sum_r);
          speed_r[axis_r] <= v_r;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_position = out_pos_r;
  assign out_new_speed    = out_spd_r;

endmodule

// ===== hdl/jog_velocity_ramp_integrator_top.sv =====
// Top level of the jog velocity ramp integrator.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    in_axis, in_key_negative, in_key_positive, in_delta_time
//   out       out_valid / out_ready  out_new_position, out_new_speed
//   cfg       APB psel/penable       cfg_paddr, cfg_pwdata, cfg_prdata
//
// Each braking or accelerating phase that ends inside the tick runs a 16-step
// restoring divider.
// in_ready is high only while the controller is idle; one item is in work at a time.
// Reset clears all axis speeds and positions and loads the register defaults.
// A result waits in the output register; the next item is accepted meanwhile and
// holds in its final step until that result is taken.
module jog_velocity_ramp_integrator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [jvr_pkg::AXIS_W-1:0]    in_axis,
  input  logic                          in_key_negative,
  input  logic                          in_key_positive,
  input  logic [jvr_pkg::DT_W-1:0]      in_delta_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [jvr_pkg::VAL_W-1:0] out_new_position,
  output logic signed [jvr_pkg::VAL_W-1:0] out_new_speed,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [3:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import jvr_pkg::*;

  cfg_t       cfg;
  dp_op_t     op;
  dp_status_t status;

  jvr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  jvr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  jvr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .status           (status),
    .cfg              (cfg),
    .in_axis          (in_axis),
    .in_key_negative  (in_key_negative),
    .in_key_positive  (in_key_positive),
    .in_delta_time    (in_delta_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_position (out_new_position),
    .out_new_speed    (out_new_speed)
  );

endmodule

// ===== dv/jog_velocity_ramp_integrator_top_tb.sv =====
// Testbench for the jog velocity ramp integrator: random jog ticks checked against a predictor.
module jog_velocity_ramp_integrator_top_tb;
  import jvr_pkg::*;

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic key_neg;
    logic key_pos;
    logic [DT_W-1:0] dt;
  } tick_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pos;
    logic signed [VAL_W-1:0] spd;
  } motion_t;

  localparam int LIMIT = 3000000;

  logic clk, rst_n;
  logic in_valid, in_ready, in_key_negative, in_key_positive;
  logic [AXIS_W-1:0] in_axis;
  logic [DT_W-1:0] in_delta_time;
  logic out_valid, out_ready;
  logic signed [VAL_W-1:0] out_new_position, out_new_speed;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  jog_velocity_ramp_integrator_top u_top (.*);

  // Predictor copy of registers and axis state.
  logic [CFG_W-1:0] span_q, vmax_q, acc_q, dec_q;
  logic [31:0] speed_q [AXES];
  logic [31:0] place_q [AXES];

  tick_t pending_ticks[$];
  motion_t expected_motion[$];
  int errors = 0;
  int beats_out = 0;
  int cycles = 0;
  bit idle_ok = 1;        // random idling enabled
  bit hold_off = 0;       // long receiver stall request
  bit in_fire = 0;        // input beat taken at the last rising edge
  int ticks_sent = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint floor_div2p(longint x, int s);
    if (x >= 0) return x >>> s;
    return -(((-x) + ((64'sd1 << s) - 1)) >>> s);
  endfunction

  function automatic motion_t step_axis(tick_t t);
    motion_t r;
    longint cmd, v, p, mov, sgn, mag, dv, tt, along, target, gap, hs;
    longint rem;
    cmd = 0;
    mov = 0;
    rem = longint'(t.dt);
    v = longint'($signed(speed_q[t.axis]));
    p = longint'($signed(place_q[t.axis]));
    if (t.key_neg) cmd -= 1;
    if (t.key_pos) cmd += 1;
    if (rem > 0 && v != 0 && cmd * v <= 0) begin
      sgn = v > 0 ? 1 : -1;
      mag = v * sgn;
      if ((mag << 16) > rem * longint'(dec_q)) begin
        dv = (rem * longint'(dec_q)) >>> 16;
        mov += (2 * v - sgn * dv) * rem;
        v -= sgn * dv;
        rem = 0;
      end else begin
        tt = (mag << 16) / longint'(dec_q);
        mov += v * tt;
        v = 0;
        rem -= tt;
      end
    end
    if (rem > 0 && cmd != 0 && cmd * v >= 0) begin
      along = cmd * v;
      target = cmd * longint'(vmax_q);
      if (along >= longint'(vmax_q)) begin
        v = target;
      end else begin
        gap = longint'(vmax_q) - along;
        if ((gap << 16) > rem * longint'(acc_q)) begin
          dv = (rem * longint'(acc_q)) >>> 16;
          mov += (2 * v + cmd * dv) * rem;
          v += cmd * dv;
          rem = 0;
        end else begin
          tt = (gap << 16) / longint'(acc_q);
          mov += (v + target) * tt;
          v = target;
          rem -= tt;
        end
      end
    end
    mov += 2 * v * rem;
    p += floor_div2p(mov + (64'sd1 << 16), 17);
    hs = longint'(span_q);
    if (p > hs) begin
      p = hs;
      v = 0;
    end else if (p < -hs) begin
      p = -hs;
      v = 0;
    end
    speed_q[t.axis] = v[31:0];
    place_q[t.axis] = p[31:0];
    r.pos = p[31:0];
    r.spd = v[31:0];
    return r;
  endfunction

  // Sender: one beat per accepted tick, random gap bursts.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && !in_fire) begin
      // hold the offered beat
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 0;
    end else if (pending_ticks.size() > 0) begin
      tick_t t;
      t = pending_ticks.pop_front();
      {in_axis, in_key_negative, in_key_positive, in_delta_time} <= t;
      in_valid <= 1;
      if (idle_ok && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 16);
    end else begin
      in_valid <= 0;
    end
  end

  // Predict at acceptance so state follows the order the block sees.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_motion.push_back(step_axis({in_axis, in_key_negative, in_key_positive,
                                           in_delta_time}));
      ticks_sent++;
    end
  end

  // Receiver stall control.
  int stall_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_off) begin
      out_ready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if (idle_ok && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      motion_t e;
      beats_out++;
      if (expected_motion.size() == 0) begin
        $error("result beat with no expectation: pos %0d speed %0d",
               out_new_position, out_new_speed);
        errors++;
      end else begin
        e = expected_motion.pop_front();
        if (out_new_position !== e.pos) begin
          $error("new_position expected %0d actual %0d", e.pos, out_new_position);
          errors++;
        end
        if (out_new_speed !== e.spd) begin
          $error("new_speed expected %0d actual %0d", e.spd, out_new_speed);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    case (idx)
      REG_HALF_SPAN: span_q = val[CFG_W-1:0];
      REG_MAX_SPEED: vmax_q = val[CFG_W-1:0];
      REG_ACCEL_RATE: acc_q = val[CFG_W-1:0];
      default: dec_q = val[CFG_W-1:0];
    endcase
  endtask

  task automatic drain();
    while (pending_ticks.size() > 0 || in_valid || expected_motion.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] hs, logic [31:0] vm, logic [31:0] ac, logic [31:0] dc);
    drain();
    write_reg(REG_HALF_SPAN, hs);
    write_reg(REG_MAX_SPEED, vm);
    write_reg(REG_ACCEL_RATE, ac);
    write_reg(REG_DECEL_RATE, dc);
  endtask

  function automatic tick_t rand_tick(bit well_formed);
    tick_t t;
    t.axis = AXIS_W'($urandom_range(0, 3));
    t.key_neg = 1'($urandom_range(0, 1));
    t.key_pos = 1'($urandom_range(0, 1));
    if (well_formed && t.key_neg && t.key_pos && $urandom_range(0, 2) != 0) t.key_neg = 0;
    case ($urandom_range(0, 5))
      0: t.dt = 16'hFFFF;
      1: t.dt = DT_W'($urandom_range(0, 3));
      2: t.dt = DT_W'($urandom_range(0, 255));
      default: t.dt = DT_W'($urandom);
    endcase
    return t;
  endfunction

  task automatic random_phase(int n);
    repeat (n) pending_ticks.push_back(rand_tick($urandom_range(0, 9) != 0));
  endtask

  initial begin
    tick_t t;
    rst_n = 0;
    in_valid = 0;
    out_ready = 0;
    {in_axis, in_key_negative, in_key_positive, in_delta_time} = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    span_q = '0;
    vmax_q = 31'd65536;
    acc_q = 31'd65536;
    dec_q = 31'd65536;
    for (int i = 0; i < AXES; i++) begin
      speed_q[i] = '0;
      place_q[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Reset values: half span 0 clamps everything to zero.
    pending_ticks.push_back('{2'd0, 1'b0, 1'b1, 16'hFFFF});
    pending_ticks.push_back('{2'd3, 1'b1, 1'b0, 16'h8000});
    set_regs(32'h7FFF_FFFF, 32'd200000, 32'd50000, 32'd80000);
    // Accelerate, over-speed, both keys, reversal, zero time.
    pending_ticks.push_back('{2'd0, 1'b0, 1'b1, 16'hFFFF});
    pending_ticks.push_back('{2'd0, 1'b0, 1'b1, 16'hFFFF});
    pending_ticks.push_back('{2'd0, 1'b0, 1'b1, 16'hFFFF});
    pending_ticks.push_back('{2'd0, 1'b0, 1'b1, 16'hFFFF});
    pending_ticks.push_back('{2'd0, 1'b1, 1'b1, 16'h4000});
    pending_ticks.push_back('{2'd0, 1'b1, 1'b0, 16'hFFFF});
    pending_ticks.push_back('{2'd0, 1'b1, 1'b0, 16'h0000});
    pending_ticks.push_back('{2'd1, 1'b1, 1'b0, 16'h0001});
    pending_ticks.push_back('{2'd2, 1'b0, 1'b0, 16'hFFFF});
    // Lower max speed makes the axis over-speed; it snaps to the new limit.
    set_regs(32'h7FFF_FFFF, 32'd1000, 32'd50000, 32'd80000);
    pending_ticks.push_back('{2'd0, 1'b1, 1'b0, 16'h1234});
    // Extreme rates and speed, zero max speed, tiny span.
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    pending_ticks.push_back('{2'd3, 1'b0, 1'b1, 16'hFFFF});
    pending_ticks.push_back('{2'd3, 1'b0, 1'b1, 16'hFFFF});
    pending_ticks.push_back('{2'd3, 1'b0, 1'b0, 16'h0001});
    set_regs(32'd5, 32'd0, 32'd1, 32'd1);
    pending_ticks.push_back('{2'd1, 1'b0, 1'b1, 16'hFFFF});
    pending_ticks.push_back('{2'd3, 1'b1, 1'b0, 16'hFFFF});
    pending_ticks.push_back('{2'd2, 1'b0, 1'b0, 16'hFFFF});

    // Random phases across several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      set_regs($urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF : $urandom_range(1, 1 << 24),
               $urandom_range(0, 4) == 0 ? 32'h7FFF_FFFF : $urandom_range(1, 1 << 20),
               ph == 1 ? 32'd1 : $urandom_range(1, 1 << 21),
               ph == 2 ? 32'h7FFF_FFFF : $urandom_range(1, 1 << 21));
      random_phase(220);
      if (ph == 2) begin
        // Long receiver hold-off while ticks keep coming.
        @(negedge clk);
        hold_off = 1;
        repeat (400) @(posedge clk);
        @(negedge clk);
        hold_off = 0;
      end
      if (ph == 4) begin
        // Sender pauses until every result is back.
        drain();
      end
    end
    set_regs(32'd40000000, 32'd300000, 32'd100000, 32'd150000);
    idle_ok = 0;
    random_phase(300);
    drain();

    $display("Covered %0d ticks and %0d result beats over several register settings,",
             ticks_sent, beats_out);
    $display("including clamps, reversals, over-speed snaps and receiver back-pressure.");
    if (errors == 0 && expected_motion.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
